// ===== sv/assert_macros.svh =====
// assertion macros shared by the sobel edge threshold rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/sbl_pkg.sv =====
// shared types and constants of the sobel edge threshold block
package sbl_pkg;

   // line buffer geometry
   localparam int LINE_MAX = 2048;
   localparam int COL_W    = $clog2(LINE_MAX);
   localparam int WIDTH_W  = 12;
   localparam int THR_W    = 11;
   localparam int CSR_W    = 12;
   localparam int POS_W    = 23;
   localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
   localparam logic [WIDTH_W-1:0] WIDTH_MIN = WIDTH_W'(3);
   localparam logic [WIDTH_W-1:0] WIDTH_MAX = WIDTH_W'(LINE_MAX);

   // gradient and magnitude widths
   localparam int GRAD_W = 10;
   localparam int SQ_W   = 2 * GRAD_W;
   localparam int T2_W   = 2 * THR_W;

   // window queue between front and back
   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef logic [7:0] pixel_type;

   // result codes
   localparam pixel_type EDGE_ON  = 8'd255;
   localparam pixel_type EDGE_OFF = 8'd0;

   // 3x3 window, index row*3+col, top row and left column first
   typedef logic [8:0][7:0] win_type;

   // register indexes of the control port
   typedef enum logic [0:0] {
      CSR_THRESHOLD  = 1'b0,
      CSR_LINE_WIDTH = 1'b1
   } csr_index_type;

   // front to queue
   typedef struct packed {
      logic    valid;
      win_type win;
   } win_push_type;

   // queue to back
   typedef struct packed {
      logic    valid;
      win_type win;
   } win_entry_type;

endpackage

// ===== sv/sobel_edge_threshold.sv =====
// top level of the sobel edge threshold block
//
//   port group   direction  handshake                   payload
//   req_         in         req_valid / req_ready       req_pixel_value, req_start_of_frame
//   rsp_         out        rsp_valid / rsp_ready       rsp_edge_value
//   csr_         in         csr_write_enable            csr_index, csr_write_data
//
// one request per cycle sustained while rsp_ready holds; the line buffer is a single-port
// read plus one write per cycle, with a same-column bypass, so nothing in the path limits
// the rate below one. a result leaves after its request has passed the front stages, the
// queue, then gradient, square and compare stages.
// synchronous reset clears control state, the window and the registers to threshold 100,
// line width 640; line buffer contents are undefined until written.
// back pressure on rsp_ fills the queue, then stalls the front and drops req_ready.

module sobel_edge_threshold (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_pixel_value,
   input  logic                          req_start_of_frame,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_edge_value,
   input  logic                          csr_write_enable,
   input  sbl_pkg::csr_index_type        csr_index,
   input  logic [sbl_pkg::CSR_W-1:0]     csr_write_data
);
   import sbl_pkg::*;

   logic [THR_W-1:0]   threshold_ff;
   logic [WIDTH_W-1:0] line_width_ff;
   win_push_type       push;
   logic               push_ready;
   win_entry_type      entry;
   logic               pop;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= THR_W'(100);
         line_width_ff <= WIDTH_W'(640);
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_THRESHOLD:  threshold_ff  <= csr_write_data[THR_W-1:0];
            CSR_LINE_WIDTH: line_width_ff <= csr_write_data[WIDTH_W-1:0];
            default:        threshold_ff  <= threshold_ff;
         endcase
      end
   end

   sbl_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_pixel_value    (req_pixel_value),
      .req_start_of_frame (req_start_of_frame),
      .line_width         (line_width_ff),
      .push               (push),
      .push_ready         (push_ready)
   );

   sbl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .entry      (entry),
      .pop        (pop)
   );

   sbl_back u_back (
      .clock          (clock),
      .reset          (reset),
      .entry          (entry),
      .pop            (pop),
      .threshold      (threshold_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_edge_value (rsp_edge_value)
   );

endmodule

// ===== sv/sbl_front.sv =====
// front: request intake, line buffers and 3x3 window
`include "assert_macros.svh"

module sbl_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  sbl_pkg::pixel_type              req_pixel_value,
   input  logic                            req_start_of_frame,
   input  logic [sbl_pkg::WIDTH_W-1:0]     line_width,
   output sbl_pkg::win_push_type           push,
   input  logic                            push_ready
);
   import sbl_pkg::*;

   logic [WIDTH_W-1:0] width_eff;
   logic [WIDTH_W:0]   emit_limit;
   logic               req_fire;
   logic [COL_W-1:0]   col_ff, col_in, col_cur;
   logic [WIDTH_W-1:0] col_start, col_next;
   logic [POS_W-1:0]   pos_ff, pos_in, pos_cur;

   logic               s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0]   s1_col_ff;
   pixel_type          s1_pix_ff;
   logic               s1_emit_ff;
   logic               s1_go;
   logic               byp_sel_ff;
   logic [15:0]        byp_data_ff;
   logic [15:0]        line_rd_ff;
   logic [15:0]        line_data;
   logic [15:0]        line_mem [LINE_MAX];
   win_type            win_ff, win_in;

   // effective width clamped to the line buffer range
   always_comb begin
      priority if (line_width < WIDTH_MIN) begin
         width_eff = WIDTH_MIN;
      end else if (line_width > WIDTH_MAX) begin
         width_eff = WIDTH_MAX;
      end else begin
         width_eff = line_width;
      end
   end
   assign emit_limit = {width_eff, 1'b0} + (WIDTH_W + 1)'(2);

   // stage b moves on unless its window waits for queue room
   assign s1_go     = s1_valid_ff && (!s1_emit_ff || push_ready);
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_fire  = req_valid && req_ready;

   // column and position of the incoming pixel
   always_comb begin
      col_start = req_start_of_frame ? '0 : WIDTH_W'(col_ff);
      col_cur   = (col_start >= width_eff) ? '0 : col_start[COL_W-1:0];
      col_next  = WIDTH_W'(col_cur) + WIDTH_W'(1);
      col_in    = (col_next >= width_eff) ? '0 : col_next[COL_W-1:0];
      pos_cur   = req_start_of_frame ? '0 : pos_ff;
      pos_in    = (pos_cur == POS_MAX) ? pos_cur : pos_cur + POS_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         pos_ff <= '0;
      end else if (req_fire) begin
         col_ff <= col_in;
         pos_ff <= pos_in;
      end
   end

   // stage b control
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // stage b payload and bypass of a same-column write in flight
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_col_ff   <= col_cur;
         s1_pix_ff   <= req_pixel_value;
         s1_emit_ff  <= ({{(POS_W - WIDTH_W - 1){1'b0}}, emit_limit} <= pos_cur);
         byp_sel_ff  <= s1_valid_ff && (s1_col_ff == col_cur);
         byp_data_ff <= {line_data[7:0], s1_pix_ff};
      end
   end

   // line buffers: upper row in the high byte, middle row in the low byte
   always_ff @(posedge clock) begin
      if (req_fire) begin
         line_rd_ff <= line_mem[col_cur];
      end
      if (s1_go) begin
         line_mem[s1_col_ff] <= {line_data[7:0], s1_pix_ff};
      end
   end

   assign line_data = byp_sel_ff ? byp_data_ff : line_rd_ff;

   // window shifts left by one pixel, new column from buffers and input
   always_comb begin
      win_in = win_ff;
      for (int r = 0; r < 3; r++) begin
         win_in[r*3]     = win_ff[r*3 + 1];
         win_in[r*3 + 1] = win_ff[r*3 + 2];
      end
      win_in[2] = line_data[15:8];
      win_in[5] = line_data[7:0];
      win_in[8] = s1_pix_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
      end else if (s1_go) begin
         win_ff <= win_in;
      end
   end

   assign push.valid = s1_valid_ff && s1_emit_ff;
   assign push.win   = win_in;

   `ASSERT_NEXT(a_sof_col_zero, req_fire && req_start_of_frame, s1_col_ff == '0,
      "frame start did not restart the column")

endmodule

// ===== sv/sbl_queue.sv =====
// short window queue between front and back
`include "assert_macros.svh"

module sbl_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  sbl_pkg::win_push_type  push,
   output logic                   push_ready,
   output sbl_pkg::win_entry_type entry,
   input  logic                   pop
);
   import sbl_pkg::*;

   win_type              slot_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [Q_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [Q_CNT_W-1:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);

   // pointer and fill count
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + Q_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + Q_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + Q_CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - Q_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // window storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.win;
      end
   end

   assign entry.valid = (count_ff != '0);
   assign entry.win   = slot_ff[rd_ptr_ff];

   `ASSERT_ALWAYS(a_count_bound, count_ff <= Q_CNT_W'(Q_DEPTH),
      "queue fill count beyond depth")
   `ASSERT_NEXT(a_count_track, do_push && !do_pop, count_ff == $past(count_ff) + Q_CNT_W'(1),
      "queue count missed a push")

endmodule

// ===== sv/sbl_back.sv =====
// back: sobel gradients, squared magnitude and threshold compare
`include "assert_macros.svh"

module sbl_back (
   input  logic                          clock,
   input  logic                          reset,
   input  sbl_pkg::win_entry_type        entry,
   output logic                          pop,
   input  logic [sbl_pkg::THR_W-1:0]     threshold,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sbl_pkg::pixel_type            rsp_edge_value
);
   import sbl_pkg::*;

   // weighted 1-2-1 sum of three pixels
   function automatic logic [GRAD_W-1:0] tap_sum(pixel_type a, pixel_type b, pixel_type c);
      return {2'b00, a} + {1'b0, b, 1'b0} + {2'b00, c};
   endfunction

   function automatic logic [GRAD_W-1:0] abs_diff(logic [GRAD_W-1:0] a,
                                                  logic [GRAD_W-1:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   logic               out_take, m_take, g_take;
   logic               g_valid_ff, m_valid_ff, rsp_valid_ff;
   logic [GRAD_W-1:0]  gx_ff, gy_ff, gx_in, gy_in;
   logic [SQ_W-1:0]    gx2_ff, gy2_ff;
   logic [T2_W-1:0]    t2_ff;
   logic [SQ_W:0]      mag2;
   pixel_type          edge_ff, edge_in;

   // stall chain from the result side back to the queue
   assign out_take = !rsp_valid_ff || rsp_ready;
   assign m_take   = !m_valid_ff || out_take;
   assign g_take   = !g_valid_ff || m_take;
   assign pop      = g_take;

   // horizontal kernel 1 0 -1 / 2 0 -2 / 1 0 -1, vertical 1 2 1 / 0 0 0 / -1 -2 -1
   always_comb begin
      gx_in = abs_diff(tap_sum(entry.win[0], entry.win[3], entry.win[6]),
                       tap_sum(entry.win[2], entry.win[5], entry.win[8]));
      gy_in = abs_diff(tap_sum(entry.win[0], entry.win[1], entry.win[2]),
                       tap_sum(entry.win[6], entry.win[7], entry.win[8]));
   end

   // squared magnitude against squared threshold
   assign mag2    = {1'b0, gx2_ff} + {1'b0, gy2_ff};
   assign edge_in = ({{(T2_W - SQ_W - 1){1'b0}}, mag2} > t2_ff) ? EDGE_ON : EDGE_OFF;

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         g_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (g_take) begin
            g_valid_ff <= entry.valid;
         end
         if (m_take) begin
            m_valid_ff <= g_valid_ff;
         end
         if (out_take) begin
            rsp_valid_ff <= m_valid_ff;
         end
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      t2_ff <= T2_W'(threshold) * T2_W'(threshold);
      if (g_take) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
      if (m_take) begin
         gx2_ff <= SQ_W'(gx_ff) * SQ_W'(gx_ff);
         gy2_ff <= SQ_W'(gy_ff) * SQ_W'(gy_ff);
      end
      if (out_take) begin
         edge_ff <= edge_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = edge_ff;

   `ASSERT_SAME(a_edge_code, rsp_valid_ff, edge_ff == EDGE_ON || edge_ff == EDGE_OFF,
      "result is neither edge nor background")

endmodule
